FILE: hdl/sdhs_pkg.sv
// Shared constants for the SCAN disk head scheduler.
`default_nettype none

package sdhs_pkg;

    // Request store geometry.
    localparam int MAX_REQUESTS = 32;
    localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);

    // Field widths.
    localparam int CYL_W      = 16;
    localparam int DISK_W     = 17;
    localparam int MOVE_W     = 22;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = 2'd2;

    // Input commands.
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    // Largest cylinder number on any disk.
    localparam logic [CYL_W-1:0] CYL_MAX = {CYL_W{1'b1}};

endpackage

`default_nettype wire

FILE: hdl/scan_disk_head_scheduler_top.sv
// Top level of the SCAN (elevator) disk head scheduler with its request memory.
`default_nettype none

// The block collects cylinder requests in a small synchronous memory, kept in
// ascending order, and on a run command serves them in SCAN (elevator) order.
// An input item with tuser = 0 adds the cylinder in tdata; once the store holds
// MAX_REQUESTS entries further adds are dropped. An item with tuser = 1 runs
// the schedule: the head starts at start_head and sweeps in the configured
// direction, serving the requests strictly above start_head when going up (or
// those at or below it when going down), travels on to the disk end (the last
// cylinder or zero), then reverses and serves the remaining group. Each served
// cylinder comes out with the running movement; a final item with tuser = 1 and
// tlast = 1 carries the total movement, and the store is then empty.
// All work goes through the single read port of the request memory, whose read
// data is registered. An add to an empty store writes the entry directly;
// otherwise the stored entries are read from the top down, each one larger
// than the new cylinder moving up one place, before the new cylinder is
// written. A run is accepted, then scans the entries in order (at most the
// request count) to find the first request above the head, starts each sweep
// and serves its requests, moves to the disk end and gives the total item; the
// output side can stall the served items and the total item. Only one input
// item is in work at a time; the result register lets the next item be
// accepted while the last result still waits to be taken. Configuration
// writes are always taken and should only be made while the block is idle.
module scan_disk_head_scheduler_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Input items.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [sdhs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] cylinder
    input  wire logic                              s_axis_tuser,  // [0] cmd

    // Result items.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [sdhs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [15:0] served_cylinder,
                                                                  // [37:16] movement_so_far,
                                                                  // [39:38] zero
    output logic                                   m_axis_tuser,  // [0] is_total
    output logic                                   m_axis_tlast,  // last

    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sdhs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sdhs_pkg::DISK_W-1:0]       cfg_data
);

    import sdhs_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_INS,
        ST_INS_WR,
        ST_SCAN,
        ST_SEG_START,
        ST_SERVE,
        ST_END_MOVE,
        ST_TOTAL
    } state_t;

    // Request memory, one write and one registered read per cycle.
    logic [CYL_W-1:0]  mem [MAX_REQUESTS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CYL_W-1:0]  mem_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CYL_W-1:0]  rd_data_reg;

    // Configuration registers.
    logic [CYL_W-1:0]  start_head_reg;
    logic [DISK_W-1:0] disk_cyl_reg;
    logic              sweep_up_reg;

    // Control and datapath state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  split_reg, split_next;
    logic              second_reg, second_next;
    logic [CYL_W-1:0]  new_cyl_reg, new_cyl_next;
    logic [CYL_W-1:0]  head_reg, head_next;
    logic [MOVE_W-1:0] total_reg, total_next;

    // Result register.
    logic              out_valid_reg;
    logic [CYL_W-1:0]  out_cyl_reg;
    logic [MOVE_W-1:0] out_move_reg;
    logic              out_total_reg;
    logic              out_load;
    logic [CYL_W-1:0]  out_cyl;
    logic              out_total;
    logic              out_free;

    logic              in_accept;
    logic              seg_up;
    logic [CYL_W-1:0]  end_cyl;
    logic [CYL_W-1:0]  move_target;
    logic [CYL_W-1:0]  move_dist;
    logic [MOVE_W-1:0] move_total;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign seg_up        = sweep_up_reg ^ second_reg;

    // Upper disk end: a size of zero acts as one cylinder, sizes above the
    // 16-bit range clamp to the top cylinder.
    always_comb
    begin
        if (disk_cyl_reg == '0)
        begin
            end_cyl = '0;
        end
        else if (disk_cyl_reg[DISK_W-1])
        begin
            end_cyl = CYL_MAX;
        end
        else
        begin
            end_cyl = CYL_W'(disk_cyl_reg - DISK_W'(1));
        end
    end

    // One head move: absolute distance added to the running total. The total
    // cannot exceed its width with 16-bit cylinders and at most 33 moves.
    always_comb
    begin
        if (state_reg == ST_END_MOVE)
        begin
            move_target = sweep_up_reg ? end_cyl : '0;
        end
        else
        begin
            move_target = rd_data_reg;
        end
        move_dist  = (move_target > head_reg) ? (move_target - head_reg)
                                              : (head_reg - move_target);
        move_total = total_reg + MOVE_W'(move_dist);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        split_next   = split_reg;
        second_next  = second_reg;
        new_cyl_next = new_cyl_reg;
        head_next    = head_reg;
        total_next   = total_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        out_load     = 1'b0;
        out_cyl      = '0;
        out_total    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == CMD_ADD)
                    begin
                        if (count_reg < CNT_W'(MAX_REQUESTS))
                        begin
                            if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = s_axis_tdata[CYL_W-1:0];
                                count_next = CNT_W'(1);
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = ADDR_W'(count_reg - CNT_W'(1));
                                idx_next     = count_reg;
                                new_cyl_next = s_axis_tdata[CYL_W-1:0];
                                state_next   = ST_INS;
                            end
                        end
                    end
                    else
                    begin
                        head_next   = start_head_reg;
                        total_next  = '0;
                        second_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            split_next = '0;
                            state_next = ST_SEG_START;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            // rd_data_reg holds entry idx-1; shift it up while it is larger.
            ST_INS:
            begin
                if (rd_data_reg > new_cyl_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[ADDR_W-1:0];
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_reg - CNT_W'(1);
                    if (idx_reg > CNT_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_W'(idx_reg - CNT_W'(2));
                    end
                    else
                    begin
                        state_next = ST_INS_WR;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg[ADDR_W-1:0];
                    mem_wdata  = new_cyl_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = new_cyl_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end

            // Find the first stored request strictly above the start cylinder.
            ST_SCAN:
            begin
                if (rd_data_reg > start_head_reg)
                begin
                    split_next = idx_reg;
                    state_next = ST_SEG_START;
                end
                else if ((idx_reg + CNT_W'(1)) == count_reg)
                begin
                    split_next = count_reg;
                    state_next = ST_SEG_START;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_W'(idx_reg + CNT_W'(1));
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_SEG_START:
            begin
                if (seg_up ? (split_reg == count_reg) : (split_reg == '0))
                begin
                    state_next = second_reg ? ST_TOTAL : ST_END_MOVE;
                end
                else if (seg_up)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = split_reg[ADDR_W-1:0];
                    idx_next   = split_reg;
                    state_next = ST_SERVE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(split_reg - CNT_W'(1));
                    idx_next   = split_reg - CNT_W'(1);
                    state_next = ST_SERVE;
                end
            end

            ST_SERVE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_cyl    = rd_data_reg;
                    head_next  = rd_data_reg;
                    total_next = move_total;
                    if (seg_up ? ((idx_reg + CNT_W'(1)) == count_reg) : (idx_reg == '0))
                    begin
                        state_next = second_reg ? ST_TOTAL : ST_END_MOVE;
                    end
                    else if (seg_up)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(idx_reg + CNT_W'(1));
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(idx_reg - CNT_W'(1));
                        idx_next = idx_reg - CNT_W'(1);
                    end
                end
            end

            ST_END_MOVE:
            begin
                head_next   = move_target;
                total_next  = move_total;
                second_next = 1'b1;
                state_next  = ST_SEG_START;
            end

            ST_TOTAL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_cyl    = '0;
                    out_total  = 1'b1;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Request memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state, configuration and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            split_reg      <= '0;
            second_reg     <= 1'b0;
            head_reg       <= '0;
            total_reg      <= '0;
            start_head_reg <= '0;
            disk_cyl_reg   <= DISK_W'(65536);
            sweep_up_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            split_reg  <= split_next;
            second_reg <= second_next;
            head_reg   <= head_next;
            total_reg  <= total_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_START_HEAD:     start_head_reg <= cfg_data[CYL_W-1:0];
                    CFG_DISK_CYLINDERS: disk_cyl_reg   <= cfg_data;
                    CFG_SWEEP_UP:       sweep_up_reg   <= cfg_data[0];
                    default:            ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload and the held new cylinder need no reset.
    always_ff @(posedge clk)
    begin
        new_cyl_reg <= new_cyl_next;
        if (out_load)
        begin
            out_cyl_reg   <= out_cyl;
            out_move_reg  <= total_next;
            out_total_reg <= out_total;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CYL_W - MOVE_W){1'b0}}, out_move_reg, out_cyl_reg};
    assign m_axis_tuser  = out_total_reg;
    assign m_axis_tlast  = out_total_reg;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the SCAN disk head scheduler, with an elevator-order scoreboard.
`timescale 1ns / 100ps

module testbench;

    import sdhs_pkg::*;

    // Run length and pacing.
    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_CYCLES   = 600;
    // An add may shift every stored entry up by one place, so the block can
    // keep working after the last result is taken.
    localparam int SETTLE_CYCLES = 80;
    localparam int MOVE_LIMIT    = (1 << MOVE_W) - 1;
    localparam int DISK_LIMIT    = 1 << CYL_W;

    // One result item, split into its fields.
    typedef struct {
        logic [CYL_W-1:0]  cylinder;
        logic [MOVE_W-1:0] movement;
        logic              total;
        logic              last;
    } scan_result_t;

    // The scoreboard keeps its own copy of the request store and the
    // configuration. Every accepted add is sorted into the store; every
    // accepted run is expanded into the served cylinders in elevator order,
    // followed by the total item.
    class scan_scoreboard;
        logic [CYL_W-1:0]  requests[MAX_REQUESTS];
        int                stored;
        logic [CYL_W-1:0]  start_head;
        logic [DISK_W-1:0] disk_cylinders;
        logic              sweep_up;
        int                head;
        int                moved;
        scan_result_t      expected_results[$];
        int                mismatches;
        int                checked;
        int                runs;
        int                requests_taken;
        int                requests_dropped;

        function new();
            stored           = 0;
            start_head       = '0;
            disk_cylinders   = DISK_W'(DISK_LIMIT);
            sweep_up         = 1'b1;
            head             = 0;
            moved            = 0;
            mismatches       = 0;
            checked          = 0;
            runs             = 0;
            requests_taken   = 0;
            requests_dropped = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DISK_W-1:0] value);
            case (idx)
                CFG_START_HEAD:     start_head = value[CYL_W-1:0];
                CFG_DISK_CYLINDERS: disk_cylinders = value;
                CFG_SWEEP_UP:       sweep_up = value[0];
                default:            ;
            endcase
        endfunction

        // Moves the head, accumulating the absolute distance up to MOVE_LIMIT.
        function void travel(int target);
            moved += (target > head) ? target - head : head - target;
            if (moved > MOVE_LIMIT)
                moved = MOVE_LIMIT;
            head = target;
        endfunction

        function void serve(int idx);
            scan_result_t r;
            travel(int'(requests[idx]));
            r.cylinder = head[CYL_W-1:0];
            r.movement = moved[MOVE_W-1:0];
            r.total    = 1'b0;
            r.last     = 1'b0;
            expected_results.push_back(r);
        endfunction

        function void note_item(logic cmd, logic [CYL_W-1:0] cyl);
            int           i;
            int           split;
            int           disk_end;
            scan_result_t r;
            if (cmd == CMD_ADD) begin
                // Adds beyond the capacity of the store are dropped silently.
                if (stored < MAX_REQUESTS) begin
                    i = stored;
                    while (i > 0 && requests[i-1] > cyl) begin
                        requests[i] = requests[i-1];
                        i--;
                    end
                    requests[i] = cyl;
                    stored++;
                    requests_taken++;
                end
                else
                    requests_dropped++;
                return;
            end
            runs++;
            // First entry strictly above the start splits the upper group off.
            split = stored;
            for (i = 0; i < stored; i++) begin
                if (requests[i] > start_head) begin
                    split = i;
                    break;
                end
            end
            disk_end = int'(disk_cylinders);
            if (disk_end == 0)
                disk_end = 1;
            if (disk_end > DISK_LIMIT)
                disk_end = DISK_LIMIT;
            disk_end = disk_end - 1;
            head  = int'(start_head);
            moved = 0;
            if (sweep_up) begin
                for (i = split; i < stored; i++)
                    serve(i);
                travel(disk_end);
                for (i = split; i > 0; i--)
                    serve(i - 1);
            end
            else begin
                for (i = split; i > 0; i--)
                    serve(i - 1);
                travel(0);
                for (i = split; i < stored; i++)
                    serve(i);
            end
            r.cylinder = '0;
            r.movement = moved[MOVE_W-1:0];
            r.total    = 1'b1;
            r.last     = 1'b1;
            expected_results.push_back(r);
            stored = 0;
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            checked++;
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("Unexpected result item: cylinder %0d movement %0d total %0b last %0b",
                             got.cylinder, got.movement, got.total, got.last);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.cylinder !== want.cylinder || got.movement !== want.movement ||
                got.total !== want.total || got.last !== want.last) begin
                if (mismatches < 10) begin
                    $display("Result item %0d differs: expected cylinder %0d movement %0d %s",
                             checked, want.cylinder, want.movement, "and flags below");
                    $display("    expected total %0b last %0b, got cylinder %0d movement %0d",
                             want.total, want.last, got.cylinder, got.movement);
                    $display("    got total %0b last %0b", got.total, got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs start at known values; they are driven at rising edges.
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [DISK_W-1:0]     cfg_data      = '0;

    scan_scoreboard sb = new();

    // Pacing controls shared between the sender and the receiver.
    logic              no_idle      = 1'b0;
    logic              hold_pending = 1'b0;
    logic [CYL_W-1:0]  cur_start    = '0;
    int                cur_disk     = DISK_LIMIT;
    logic [CYL_W-1:0]  last_cyl     = '0;
    int                settings     = 1;
    scan_result_t      seen_result;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    scan_disk_head_scheduler_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Idle gap length: mostly none or short, now and then a long one. In a
    // stretch without idling both sides run flat out.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request cylinders cluster on the interesting spots: the disk extremes,
    // the start position (so that the split between the groups is exercised),
    // the configured disk end and duplicates of the previous request.
    function automatic logic [CYL_W-1:0] pick_cylinder();
        int               r;
        logic [CYL_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 10)
            c = '0;
        else if (r < 20)
            c = CYL_MAX;
        else if (r < 45)
            c = CYL_W'(int'(cur_start) + $urandom_range(0, 4) - 2);
        else if (r < 55)
            c = CYL_W'(cur_disk - 1 + $urandom_range(0, 2) - 1);
        else if (r < 65)
            c = last_cyl;
        else
            c = CYL_W'($urandom);
        last_cyl = c;
        return c;
    endfunction

    // Offers one input item after a random gap and waits for its acceptance.
    task automatic send_item(input logic cmd, input logic [CYL_W-1:0] cyl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= cyl;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Writes all three registers back to back; valid stays high in between.
    task automatic write_config(input logic [CYL_W-1:0] head, input logic [DISK_W-1:0] cyls,
                                input logic up);
        logic [DISK_W-1:0]    values[3];
        logic [CFG_IDX_W-1:0] regs[3];
        int                   k;
        regs[0]   = CFG_START_HEAD;
        regs[1]   = CFG_DISK_CYLINDERS;
        regs[2]   = CFG_SWEEP_UP;
        values[0] = {1'b0, head};
        values[1] = cyls;
        values[2] = {{(DISK_W-1){1'b0}}, up};
        for (k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= values[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(regs[k], values[k]);
        end
        cfg_valid <= 1'b0;
        cur_start = head;
        cur_disk  = (cyls == 0) ? 1 : ((int'(cyls) > DISK_LIMIT) ? DISK_LIMIT : int'(cyls));
        settings++;
    endtask

    // Picks a setting, with the extremes of every register weighted up.
    task automatic random_config();
        logic [CYL_W-1:0]  head;
        logic [DISK_W-1:0] cyls;
        case ($urandom_range(0, 5))
            0:       head = '0;
            1:       head = CYL_MAX;
            2:       head = CYL_W'($urandom_range(0, 300));
            default: head = CYL_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       cyls = '0;
            1:       cyls = DISK_W'(1);
            2:       cyls = DISK_W'(DISK_LIMIT);
            3:       cyls = '1;
            4:       cyls = DISK_W'($urandom_range(2, 300));
            default: cyls = DISK_W'($urandom_range(1, (1 << DISK_W) - 1));
        endcase
        write_config(head, cyls, 1'($urandom_range(0, 1)));
    endtask

    // Lets the block drain: all expected results taken, then a pause long
    // enough for a trailing add to finish its shifting. The first edge lets
    // the monitor note the item accepted at the edge the sender returned on.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A batch of adds with random content closed by a run command. With hold
    // set, the receiver stops taking results just as the run goes in.
    task automatic run_batch(input int adds, input logic hold);
        int k;
        for (k = 0; k < adds; k++)
            send_item(CMD_ADD, pick_cylinder());
        if (hold)
            hold_pending = 1'b1;
        send_item(CMD_RUN, CYL_W'($urandom));
    endtask

    // Receiver: random stalls, and once a long hold-off counted here while
    // the sender keeps offering items, so that the block backs up.
    initial
    begin : result_sink
        int span;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (no_idle)
                m_axis_tready <= 1'b1;
            else begin
                span = pick_gap();
                if (span > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 5)) @(posedge clk);
            end
        end
    end

    // Both handshakes are sampled at the rising edge, before any of the
    // nonblocking updates made at that edge take effect.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result.cylinder = m_axis_tdata[CYL_W-1:0];
                seen_result.movement = m_axis_tdata[CYL_W +: MOVE_W];
                seen_result.total    = m_axis_tuser;
                seen_result.last     = m_axis_tlast;
                sb.check_result(seen_result);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser, s_axis_tdata[CYL_W-1:0]);
        end
    end

    initial
    begin : stimulus
        int   random_items;
        int   nadds;
        int   nruns;
        int   k;
        int   failures;
        logic first;
        random_items = 0;
        first        = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset setting: head at zero sweeping up on the largest disk. A run
        // on an empty store still moves the head to the disk end and gives
        // the total item alone. Duplicates at the head go to the lower group.
        send_item(CMD_RUN, CYL_MAX);
        send_item(CMD_ADD, CYL_MAX);
        send_item(CMD_ADD, 16'd0);
        send_item(CMD_ADD, 16'd0);
        send_item(CMD_ADD, 16'd1234);
        send_item(CMD_RUN, 16'd0);
        finish_phase();

        // Head at the top, disk size zero (one cylinder), sweeping down:
        // requests lie beyond the disk end, and an empty run follows.
        write_config(CYL_MAX, '0, 1'b0);
        send_item(CMD_ADD, CYL_MAX);
        send_item(CMD_ADD, 16'd7);
        send_item(CMD_ADD, CYL_MAX);
        send_item(CMD_RUN, 16'h5A5A);
        send_item(CMD_RUN, 16'hA5A5);
        finish_phase();

        // One cylinder and a head beyond it: the move to the end goes down.
        write_config(16'd100, DISK_W'(1), 1'b1);
        send_item(CMD_ADD, 16'd100);
        send_item(CMD_ADD, 16'd101);
        send_item(CMD_ADD, 16'd50);
        send_item(CMD_RUN, 16'd0);
        finish_phase();

        // Oversized disk register, head in the middle, sweeping down.
        write_config(16'd32768, '1, 1'b0);
        send_item(CMD_ADD, 16'd40000);
        send_item(CMD_ADD, 16'd32768);
        send_item(CMD_ADD, 16'd5);
        send_item(CMD_RUN, 16'd0);
        finish_phase();

        // Random part: each phase picks a setting and sends a few batches.
        // The first batch overfills the store under the long hold-off, and
        // further batches follow it so that the input backs up meanwhile.
        while (random_items < RANDOM_ITEMS) begin
            random_config();
            no_idle = ($urandom_range(0, 3) == 0);
            nruns   = first ? 3 : $urandom_range(1, 4);
            for (k = 0; k < nruns; k++) begin
                if (first)
                    nadds = MAX_REQUESTS + 2;
                else if ($urandom_range(0, 9) == 0)
                    nadds = $urandom_range(MAX_REQUESTS - 2, MAX_REQUESTS + 4);
                else
                    nadds = $urandom_range(0, 8);
                run_batch(nadds, first);
                random_items += ((nadds < MAX_REQUESTS) ? nadds : MAX_REQUESTS) + 1;
                first = 1'b0;
            end
            finish_phase();
        end

        failures = sb.mismatches + sb.expected_results.size();
        $display("Ran %0d schedules over %0d register settings: %0d requests stored, %0d dropped.",
                 sb.runs, settings, sb.requests_taken, sb.requests_dropped);
        $display("Checked %0d result items, %0d mismatched, %0d still outstanding.",
                 sb.checked, sb.mismatches, sb.expected_results.size());
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
